@@ hw/rtl/bdfhx_pkg.sv @@
// Shared types and constants for the BDF history and right-hand-side pipeline.
`default_nettype none

package bdfhx_pkg;

  // History store geometry
  localparam int VECTOR_LEN = 1024;
  localparam int IDX_W      = $clog2(VECTOR_LEN);

  // Item kinds
  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic REG_ORDER  = 1'b0;
  localparam logic REG_INV_DT = 1'b1;

  // BDF orders
  localparam logic [1:0] ORDER_ONE   = 2'd1;
  localparam logic [1:0] ORDER_TWO   = 2'd2;
  localparam logic [1:0] ORDER_THREE = 2'd3;

  localparam logic [31:0] INV_DT_RESET = 32'h0001_0000;

  // One third in Q16, applied to the oldest slot at order three
  localparam logic signed [51:0] ALPHA_THIRD = 52'sd21845;

  // Rounding and saturation
  localparam logic [63:0]        ROUND_HALF  = 64'h0000_0000_8000_0000;
  localparam logic [51:0]        RHS_MAX_MAG = 52'h0_7FFF_FFFF_FFFF;
  localparam logic [51:0]        RHS_MIN_MAG = 52'h0_8000_0000_0000;
  localparam logic signed [47:0] RHS_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] RHS_MIN     = 48'sh8000_0000_0000;

  // Three history slots of one element
  typedef struct packed {
    logic signed [31:0] newest;
    logic signed [31:0] previous;
    logic signed [31:0] oldest;
  } hist_t;

  // Element history after the item's action
  typedef struct packed {
    logic [9:0] echo;
    hist_t      hist;
  } hist_item_t;

  // Weighted terms (alpha in Q16, beta as unscaled integers)
  typedef struct packed {
    logic [9:0]         echo;
    logic signed [51:0] t0;
    logic signed [51:0] t1;
    logic signed [51:0] t2;
    logic signed [35:0] u0;
    logic signed [35:0] u1;
    logic signed [35:0] u2;
  } term_item_t;

  // Weighted sums
  typedef struct packed {
    logic [9:0]         echo;
    logic signed [51:0] s;
    logic signed [35:0] x;
  } sum_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdfhx_hist_store.sv @@
// History memory with read-modify-write stage and last-write forwarding.
`default_nettype none

module bdfhx_hist_store (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_take,
  input  bdfhx_pkg::kind_t       in_kind,
  input  logic [9:0]             in_index,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  output bdfhx_pkg::hist_item_t  out_item,
  input  logic                   out_take
);
  import bdfhx_pkg::*;

  // Read stage
  logic               b_valid;
  kind_t              b_kind;
  logic [9:0]         b_echo;
  logic signed [31:0] b_value;
  hist_t              rdata;

  // Last write, forwarded over the stale read
  logic               lw_valid;
  logic [IDX_W-1:0]   lw_addr;
  hist_t              lw_data;

  // Update stage
  logic               c_valid;
  hist_item_t         c_item;

  hist_t              mem [VECTOR_LEN];

  logic               en_b;
  logic               en_c;
  logic               accept;
  logic [IDX_W-1:0]   b_addr;
  hist_t              cur;
  hist_t              hist_next;
  logic               b_write;
  logic               wr_en;

  assign en_c    = !c_valid || out_take;
  assign en_b    = !b_valid || en_c;
  assign in_take = en_b;
  assign accept  = in_valid && en_b;
  assign b_addr  = b_echo[IDX_W-1:0];
  assign wr_en   = b_valid && en_c && b_write;

  // Apply the item's action to the current history
  always_comb begin
    cur = (lw_valid && (lw_addr == b_addr)) ? lw_data : rdata;
    case (b_kind)
      KIND_INIT: begin
        hist_next.newest   = b_value;
        hist_next.previous = b_value;
        hist_next.oldest   = b_value;
        b_write            = 1'b1;
      end
      KIND_PUSH: begin
        hist_next.newest   = b_value;
        hist_next.previous = cur.newest;
        hist_next.oldest   = cur.previous;
        b_write            = 1'b1;
      end
      default: begin
        hist_next = cur;
        b_write   = 1'b0;
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (en_b) b_valid <= in_valid;
      if (en_c) c_valid <= b_valid;
      if (wr_en) lw_valid <= 1'b1;
    end
  end

  // Read on accept, write back as the item leaves the read stage
  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind  <= in_kind;
      b_echo  <= in_index;
      b_value <= in_value;
      rdata   <= mem[in_index[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[b_addr] <= hist_next;
      lw_addr     <= b_addr;
      lw_data     <= hist_next;
    end
    if (en_c && b_valid) begin
      c_item.echo <= b_echo;
      c_item.hist <= hist_next;
    end
  end

  assign out_valid = c_valid;
  assign out_item  = c_item;

  // A stalled item in the read stage keeps its slot and address
  a_b_hold : assert property (@(posedge clk) disable iff (rst)
    (b_valid && !en_c) |=> (b_valid && $stable(b_echo)))
    else $error("read stage lost a stalled word");

endmodule

`default_nettype wire

@@ hw/rtl/bdfhx_weigh.sv @@
// Coefficient weighting of the history and summation of the terms.
`default_nettype none

module bdfhx_weigh (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             order,
  input  logic                   in_valid,
  output logic                   in_take,
  input  bdfhx_pkg::hist_item_t  in_item,
  output logic                   out_valid,
  output bdfhx_pkg::sum_item_t   out_item,
  input  logic                   out_take
);
  import bdfhx_pkg::*;

  logic               d_valid;
  term_item_t         d_item;
  logic               e_valid;
  sum_item_t          e_item;

  logic               en_d;
  logic               en_e;
  logic signed [51:0] h0e;
  logic signed [51:0] h1e;
  logic signed [51:0] h2e;
  logic signed [35:0] g0;
  logic signed [35:0] g1;
  logic signed [35:0] g2;
  term_item_t         terms;

  assign en_e    = !e_valid || out_take;
  assign en_d    = !d_valid || en_e;
  assign in_take = en_d;

  assign h0e = 52'(in_item.hist.newest);
  assign h1e = 52'(in_item.hist.previous);
  assign h2e = 52'(in_item.hist.oldest);
  assign g0  = 36'(in_item.hist.newest);
  assign g1  = 36'(in_item.hist.previous);
  assign g2  = 36'(in_item.hist.oldest);

  // Form alpha and beta terms for the selected order
  always_comb begin
    terms.echo = in_item.echo;
    terms.t0   = '0;
    terms.t1   = '0;
    terms.t2   = '0;
    terms.u0   = '0;
    terms.u1   = '0;
    terms.u2   = '0;
    case (order)
      ORDER_ONE: begin
        terms.t0 = h0e <<< 16;
        terms.u0 = g0;
      end
      ORDER_TWO: begin
        terms.t0 = h0e <<< 17;
        terms.t1 = -(h1e <<< 15);
        terms.u0 = g0 <<< 1;
        terms.u1 = -g1;
      end
      ORDER_THREE: begin
        terms.t0 = (h0e <<< 17) + (h0e <<< 16);
        terms.t1 = -((h1e <<< 16) + (h1e <<< 15));
        terms.t2 = h2e * ALPHA_THIRD;
        terms.u0 = (g0 <<< 1) + g0;
        terms.u1 = -((g1 <<< 1) + g1);
        terms.u2 = g2;
      end
      default: begin
        terms.t0 = '0;
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (en_d) d_valid <= in_valid;
      if (en_e) e_valid <= d_valid;
    end
  end

  // Register terms, then sums
  always_ff @(posedge clk) begin
    if (en_d && in_valid) d_item <= terms;
    if (en_e && d_valid) begin
      e_item.echo <= d_item.echo;
      e_item.s    <= d_item.t0 + d_item.t1 + d_item.t2;
      e_item.x    <= d_item.u0 + d_item.u1 + d_item.u2;
    end
  end

  assign out_valid = e_valid;
  assign out_item  = e_item;

endmodule

`default_nettype wire

@@ hw/rtl/bdfhx_scale.sv @@
// Scale by inv_dt with rounding and saturation; output register.
`default_nettype none

module bdfhx_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           inv_dt,
  input  logic                  in_valid,
  output logic                  in_take,
  input  bdfhx_pkg::sum_item_t  in_item,
  output logic                  out_valid,
  output logic [9:0]            element_echo,
  output logic signed [47:0]    rhs_value,
  output logic signed [35:0]    extrapolated,
  input  logic                  out_take
);
  import bdfhx_pkg::*;

  // Magnitude stage
  logic               f_valid;
  logic [9:0]         f_echo;
  logic               f_neg;
  logic [50:0]        f_mag;
  logic signed [35:0] f_x;

  // Product stage
  logic               g_valid;
  logic [9:0]         g_echo;
  logic               g_neg;
  logic [50:0]        g_hi;
  logic [63:0]        g_lo;
  logic signed [35:0] g_x;

  logic               en_f;
  logic               en_g;
  logic               en_h;
  logic [63:0]        lo_round;
  logic [51:0]        r;
  logic [51:0]        r_neg;
  logic signed [47:0] rhs_next;

  assign en_h    = !out_valid || out_take;
  assign en_g    = !g_valid || en_h;
  assign en_f    = !f_valid || en_g;
  assign in_take = en_f;

  // Round half away from zero on the magnitude, then saturate
  always_comb begin
    lo_round = g_lo + ROUND_HALF;
    r        = 52'(g_hi) + 52'(lo_round[63:32]);
    r_neg    = 52'd0 - r;
    if (g_neg) begin
      rhs_next = (r > RHS_MIN_MAG) ? RHS_MIN : $signed(r_neg[47:0]);
    end else begin
      rhs_next = (r > RHS_MAX_MAG) ? RHS_MAX : $signed(r[47:0]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_f) f_valid <= in_valid;
      if (en_g) g_valid <= f_valid;
      if (en_h) out_valid <= g_valid;
    end
  end

  // Sign and magnitude, split products, result word
  always_ff @(posedge clk) begin
    if (en_f && in_valid) begin
      f_echo <= in_item.echo;
      f_neg  <= in_item.s[51];
      f_mag  <= 51'(in_item.s[51] ? -in_item.s : in_item.s);
      f_x    <= in_item.x;
    end
    if (en_g && f_valid) begin
      g_echo <= f_echo;
      g_neg  <= f_neg;
      g_hi   <= 51'(f_mag[50:32]) * 51'(inv_dt);
      g_lo   <= 64'(f_mag[31:0]) * 64'(inv_dt);
      g_x    <= f_x;
    end
    if (en_h && g_valid) begin
      element_echo <= g_echo;
      rhs_value    <= rhs_next;
      extrapolated <= g_x;
    end
  end

  // A non-negative sum never yields a negative right-hand side
  a_sign_kept : assert property (@(posedge clk) disable iff (rst)
    (en_h && g_valid && !g_neg) |=> !rhs_value[47])
    else $error("positive sum produced negative rhs");

endmodule

`default_nettype wire

@@ hw/rtl/bdf_history_rhs_extrapolator.sv @@
// Top level: configuration registers and the history / weighting / scaling pipeline.
// A result word passes the read, update, terms, sums, magnitude, product and output
// registers. Throughput: one word per cycle while out_stall is low; the history memory
// does at most one read and one write each cycle, and a same-element word right behind
// takes the last write forwarded. Stalls travel back stage by stage, so bubbles fill
// before the input stalls. Reset clears valid bits and sets order to 1 and inv_dt to
// 1.0; history is undefined until an element is initialized.
`default_nettype none

module bdf_history_rhs_extrapolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [9:0]         element_index,
  input  logic signed [31:0] sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         element_echo,
  output logic signed [47:0] rhs_value,
  output logic signed [35:0] extrapolated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import bdfhx_pkg::*;

  logic [1:0]  order;
  logic [31:0] inv_dt;

  logic        hs_take;
  logic        hs_valid;
  hist_item_t  hs_item;
  logic        wg_take;
  logic        wg_valid;
  sum_item_t   wg_item;
  logic        sc_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = !hs_take;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      order  <= ORDER_ONE;
      inv_dt <= INV_DT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER:  order  <= cfg_data[1:0];
        REG_INV_DT: inv_dt <= cfg_data;
      endcase
    end
  end

  bdfhx_hist_store u_hist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_take   (hs_take),
    .in_kind   (kind_t'(kind)),
    .in_index  (element_index),
    .in_value  (sample_value),
    .out_valid (hs_valid),
    .out_item  (hs_item),
    .out_take  (wg_take)
  );

  bdfhx_weigh u_weigh (
    .clk       (clk),
    .rst       (rst),
    .order     (order),
    .in_valid  (hs_valid),
    .in_take   (wg_take),
    .in_item   (hs_item),
    .out_valid (wg_valid),
    .out_item  (wg_item),
    .out_take  (sc_take)
  );

  bdfhx_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .inv_dt       (inv_dt),
    .in_valid     (wg_valid),
    .in_take      (sc_take),
    .in_item      (wg_item),
    .out_valid    (out_valid),
    .element_echo (element_echo),
    .rhs_value    (rhs_value),
    .extrapolated (extrapolated),
    .out_take     (!out_stall)
  );

  // An empty output register never backs up the input
  a_no_false_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
